FILE: rtl/isa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isa_pkg: shared types and constants for the indexed shift array
// sizes, command and status codes, and the control bundle broadcast to cells
// ----------------------------------------------------------------------------
package isa_pkg;

	localparam int DEPTH      = 64;
	localparam int DATA_WIDTH = 32;
	localparam int VAL_W      = 32;
	localparam int IDX_W      = $clog2(DEPTH);
	localparam int CNT_W      = $clog2(DEPTH + 1);

	typedef logic [DATA_WIDTH-1:0] word_t;

	typedef enum logic [2:0] {
		CMD_READ   = 3'd0,
		CMD_APPEND = 3'd1,
		CMD_DROP   = 3'd2,
		CMD_INSERT = 3'd3,
		CMD_REMOVE = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// broadcast to every cell; the enables are only set when the command succeeds
	typedef struct packed {
		logic             ins;
		logic             rem;
		logic             app;
		logic [IDX_W-1:0] pos;
		logic [CNT_W-1:0] fill;
	} isa_op_t;

endpackage

FILE: rtl/isa_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isa_cell: one entry of the shift array
// holds a word, loads from either neighbour or the new word, offers a read term
// ----------------------------------------------------------------------------
module isa_cell import isa_pkg::*; (
	input  logic             clk,
	input  isa_op_t          op,
	input  logic [IDX_W-1:0] slot,
	input  word_t            word,
	input  word_t            prev_entry,
	input  word_t            next_entry,
	output word_t            entry,
	output word_t            rd_term
);

	word_t            entry_q;
	logic [CNT_W-1:0] slot_w;
	logic             take_prev;
	logic             take_next;
	logic             take_word;

	always_comb begin
		slot_w    = CNT_W'(slot);
		take_prev = op.ins && (slot > op.pos) && (slot_w <= op.fill);
		take_next = op.rem && (slot >= op.pos) && ((slot_w + CNT_W'(1)) < op.fill);
		take_word = (op.ins && (slot == op.pos)) || (op.app && (slot_w == op.fill));
	end

	always_ff @(posedge clk) begin
		if (take_word) begin
			entry_q <= word;
		end else if (take_prev) begin
			entry_q <= prev_entry;
		end else if (take_next) begin
			entry_q <= next_entry;
		end
	end

	assign entry   = entry_q;
	assign rd_term = (slot == op.pos) ? entry_q : '0;

endmodule

FILE: rtl/indexed_shift_array.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_shift_array: ordered list of signed words with a fill count
// read, append, drop last, insert at index and remove at index over a row of cells
// ----------------------------------------------------------------------------
//
//  channel   ports                         handshake
//  -------   ---------------------------   ------------------------------------
//  command   command, index, value         taken when start is high, busy low
//  result    status, read_value, count     shown for one cycle while done high
//
//  per item, every cell loads its new contents in the same edge
//  the result appears on the cycle after the item is taken, one result per item
//  busy is never raised, so a new item may follow in every cycle
//  reset clears the fill count and the result strobe; cell contents are left as is
//  the receiver cannot stall, so results are never held back
//
module indexed_shift_array import isa_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  logic [2:0]       command,
	input  logic [IDX_W-1:0] index,
	input  logic signed [VAL_W-1:0] value,
	output logic             done,
	output logic [1:0]       status,
	output logic signed [VAL_W-1:0] read_value,
	output logic [CNT_W-1:0] count
);

	// fill count and registered result
	logic [CNT_W-1:0]        fill_q;
	logic                    done_q;
	logic [1:0]              status_q;
	logic [VAL_W-1:0]        read_value_q;
	logic [CNT_W-1:0]        count_q;

	// decode
	logic                    accept;
	logic                    in_range;
	logic                    full;
	logic                    empty;
	status_t                 status_d;
	logic [CNT_W-1:0]        fill_d;
	logic                    rd_ok;
	isa_op_t                 op;
	word_t                   word;

	// cell row
	word_t                   entry   [DEPTH];
	word_t                   rd_term [DEPTH];
	word_t                   rd_word;

	assign accept   = start && !busy;
	assign in_range = CNT_W'(index) < fill_q;
	assign full     = (fill_q == CNT_W'(DEPTH));
	assign empty    = (fill_q == '0);

	// cast the incoming value to the storage width; both are 32 bits, so nothing is extended
	assign word = DATA_WIDTH'(value);

	always_comb begin
		status_d = ST_OK;
		fill_d   = fill_q;
		rd_ok    = 1'b0;
		op.ins   = 1'b0;
		op.rem   = 1'b0;
		op.app   = 1'b0;
		op.pos   = index;
		op.fill  = fill_q;
		case (command)
			CMD_READ: begin
				if (in_range) begin
					rd_ok = 1'b1;
				end else begin
					status_d = ST_RANGE;
				end
			end
			CMD_APPEND: begin
				if (full) begin
					status_d = ST_FULL;
				end else begin
					op.app = accept;
					fill_d = fill_q + CNT_W'(1);
				end
			end
			CMD_DROP: begin
				if (empty) begin
					status_d = ST_RANGE;
				end else begin
					fill_d = fill_q - CNT_W'(1);
				end
			end
			CMD_INSERT: begin
				// range is checked before fullness
				if (!in_range) begin
					status_d = ST_RANGE;
				end else if (full) begin
					status_d = ST_FULL;
				end else begin
					op.ins = accept;
					fill_d = fill_q + CNT_W'(1);
				end
			end
			CMD_REMOVE: begin
				if (!in_range) begin
					status_d = ST_RANGE;
				end else begin
					op.rem = accept;
					fill_d = fill_q - CNT_W'(1);
				end
			end
			default: begin
				status_d = ST_RANGE;
			end
		endcase
	end

	// row of cells, each wired to its neighbours; the two end cells see zero beyond the row
	for (genvar k = 0; k < DEPTH; k++) begin : g_cell
		word_t prev_w;
		word_t next_w;
		if (k == 0) begin : g_first
			assign prev_w = '0;
		end else begin : g_mid_p
			assign prev_w = entry[k-1];
		end
		if (k == DEPTH - 1) begin : g_last
			assign next_w = '0;
		end else begin : g_mid_n
			assign next_w = entry[k+1];
		end
		isa_cell u_cell (
			.clk        (clk),
			.op         (op),
			.slot       (IDX_W'(k)),
			.word       (word),
			.prev_entry (prev_w),
			.next_entry (next_w),
			.entry      (entry[k]),
			.rd_term    (rd_term[k])
		);
	end

	// only the addressed cell offers a non-zero term
	always_comb begin
		rd_word = '0;
		for (int k = 0; k < DEPTH; k++) begin
			rd_word = rd_word | rd_term[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= accept;
			if (accept) begin
				fill_q <= fill_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q     <= status_d;
			read_value_q <= rd_ok ? VAL_W'(rd_word) : '0;
			count_q      <= fill_d;
		end
	end

	assign busy       = 1'b0;
	assign done       = done_q;
	assign status     = status_q;
	assign read_value = read_value_q;
	assign count      = count_q;

	// every taken item gives its result on the next cycle
	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> done)
		else $error("taken item gave no result");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		!(start && !busy) |=> !done)
		else $error("result without a taken item");

	// the fill count never passes the capacity
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(DEPTH))
		else $error("fill count beyond capacity");

	// a full report only comes with a full list
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_FULL) |-> (count == CNT_W'(DEPTH)))
		else $error("full reported below capacity");

	// a failed command leaves the fill count alone
	a_fail_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && status_d != ST_OK) |=> (fill_q == $past(fill_q)))
		else $error("failed command changed the count");

endmodule

FILE: test/indexed_shift_array_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_shift_array_test: self-checking bench for the indexed shift array
// a short table of directed items, then random list traffic that fills and
// drains the list, each result checked against a typed-in row or a list model
// ----------------------------------------------------------------------------
module indexed_shift_array_test;
	import isa_pkg::*;

	// command codes the block does not decode, all reported as out of range
	localparam logic [2:0] CMD_UNUSED_LO  = 3'd5;
	localparam logic [2:0] CMD_UNUSED_MID = 3'd6;
	localparam logic [2:0] CMD_UNUSED_HI  = 3'd7;

	localparam int N_DIRECTED = 25;
	localparam int PHASE_ITEMS = 425;

	// one result as the block shows it
	typedef struct packed {
		logic [1:0]       st;
		logic [VAL_W-1:0] rd;
		logic [CNT_W-1:0] cnt;
	} list_outcome_t;

	// one directed row: the item and, where fixed is set, the result typed in
	typedef struct packed {
		logic [2:0]       cmd;
		logic [IDX_W-1:0] idx;
		logic [VAL_W-1:0] val;
		logic             fixed;
		logic [1:0]       st;
		logic [VAL_W-1:0] rd;
		logic [CNT_W-1:0] cnt;
	} list_row_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    start = 1'b0;
	logic [2:0]              command = '0;
	logic [IDX_W-1:0]        index = '0;
	logic signed [VAL_W-1:0] value = '0;
	logic                    busy;
	logic                    done;
	logic [1:0]              status;
	logic signed [VAL_W-1:0] read_value;
	logic [CNT_W-1:0]        count;

	// local copy of the list, advanced as each item is taken
	word_t list_words [DEPTH];
	int    list_fill = 0;

	list_outcome_t outcomes_due [$];
	int            mismatch_count = 0;

	// directed items: empty-list errors, unused commands, extremes, shifts
	list_row_t directed_rows [N_DIRECTED] = '{
		'{CMD_READ,       6'd0,  32'h0000_0000, 1'b1, ST_RANGE, 32'h0, 7'd0},
		'{CMD_DROP,       6'd0,  32'h0000_0000, 1'b1, ST_RANGE, 32'h0, 7'd0},
		'{CMD_REMOVE,     6'd0,  32'h0000_0000, 1'b1, ST_RANGE, 32'h0, 7'd0},
		'{CMD_INSERT,     6'd0,  32'h1234_5678, 1'b1, ST_RANGE, 32'h0, 7'd0},
		'{CMD_UNUSED_LO,  6'd0,  32'h0000_0000, 1'b1, ST_RANGE, 32'h0, 7'd0},
		'{CMD_UNUSED_MID, 6'd21, 32'h0000_0001, 1'b1, ST_RANGE, 32'h0, 7'd0},
		'{CMD_UNUSED_HI,  6'd63, 32'hffff_ffff, 1'b1, ST_RANGE, 32'h0, 7'd0},
		'{CMD_APPEND,     6'd63, 32'h8000_0000, 1'b1, ST_OK,    32'h0, 7'd1},
		'{CMD_APPEND,     6'd0,  32'h7fff_ffff, 1'b1, ST_OK,    32'h0, 7'd2},
		'{CMD_READ,       6'd0,  32'hffff_ffff, 1'b1, ST_OK,    32'h8000_0000, 7'd2},
		'{CMD_READ,       6'd1,  32'h0000_0000, 1'b1, ST_OK,    32'h7fff_ffff, 7'd2},
		'{CMD_READ,       6'd2,  32'h0000_0000, 1'b1, ST_RANGE, 32'h0, 7'd2},
		'{CMD_INSERT,     6'd2,  32'h0bad_0bad, 1'b1, ST_RANGE, 32'h0, 7'd2},
		'{CMD_INSERT,     6'd0,  32'h0000_0000, 1'b0, ST_OK,    32'h0, 7'd0},
		'{CMD_INSERT,     6'd1,  32'hffff_ffff, 1'b0, ST_OK,    32'h0, 7'd0},
		'{CMD_READ,       6'd0,  32'h0000_0000, 1'b0, ST_OK,    32'h0, 7'd0},
		'{CMD_READ,       6'd1,  32'h0000_0000, 1'b0, ST_OK,    32'h0, 7'd0},
		'{CMD_READ,       6'd2,  32'h0000_0000, 1'b0, ST_OK,    32'h0, 7'd0},
		'{CMD_READ,       6'd3,  32'h0000_0000, 1'b0, ST_OK,    32'h0, 7'd0},
		'{CMD_REMOVE,     6'd1,  32'h0000_0000, 1'b0, ST_OK,    32'h0, 7'd0},
		'{CMD_REMOVE,     6'd63, 32'h0000_0000, 1'b1, ST_RANGE, 32'h0, 7'd3},
		'{CMD_READ,       6'd63, 32'h0000_0000, 1'b1, ST_RANGE, 32'h0, 7'd3},
		'{CMD_DROP,       6'd42, 32'h0000_0000, 1'b0, ST_OK,    32'h0, 7'd0},
		'{CMD_READ,       6'd1,  32'h0000_0000, 1'b0, ST_OK,    32'h0, 7'd0},
		'{CMD_APPEND,     6'd0,  32'h5555_aaaa, 1'b0, ST_OK,    32'h0, 7'd0}
	};

	indexed_shift_array u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.command    (command),
		.index      (index),
		.value      (value),
		.done       (done),
		.status     (status),
		.read_value (read_value),
		.count      (count)
	);

	always #4 clk = ~clk;

	// one line per mismatch, and a running count
	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t ns mismatch: %s got %0h expected %0h", $realtime, what, got, want);
		mismatch_count++;
	endtask

	// apply one command to the local list and work out the result it gives
	task automatic predict_list_op(input logic [2:0] cmd, input logic [IDX_W-1:0] idx,
			input logic [VAL_W-1:0] val, output list_outcome_t res);
		int k;
		int pos;
		pos = int'(idx);
		res.st = ST_OK;
		res.rd = '0;
		case (cmd)
			CMD_READ: begin
				if (pos < list_fill)
					res.rd = list_words[pos];
				else
					res.st = ST_RANGE;
			end
			CMD_APPEND: begin
				if (list_fill >= DEPTH) begin
					res.st = ST_FULL;
				end else begin
					list_words[list_fill] = val;
					list_fill++;
				end
			end
			CMD_DROP: begin
				if (list_fill == 0)
					res.st = ST_RANGE;
				else
					list_fill--;
			end
			CMD_INSERT: begin
				// index must name an existing entry; range is judged before full
				if (pos >= list_fill) begin
					res.st = ST_RANGE;
				end else if (list_fill >= DEPTH) begin
					res.st = ST_FULL;
				end else begin
					for (k = list_fill; k > pos; k--)
						list_words[k] = list_words[k-1];
					list_words[pos] = val;
					list_fill++;
				end
			end
			CMD_REMOVE: begin
				if (pos >= list_fill) begin
					res.st = ST_RANGE;
				end else begin
					for (k = pos + 1; k < list_fill; k++)
						list_words[k-1] = list_words[k];
					list_fill--;
				end
			end
			default: begin
				res.st = ST_RANGE;
			end
		endcase
		res.cnt = list_fill[CNT_W-1:0];
	endtask

	// offer one item, wait until it is taken, note what it should give, then
	// perhaps leave the command port idle for a while with junk on the fields
	task automatic issue_item(input logic [2:0] cmd, input logic [IDX_W-1:0] idx,
			input logic [VAL_W-1:0] val, input logic fixed, input list_outcome_t fixed_res,
			input int idle_pct);
		list_outcome_t res;
		start   <= 1'b1;
		command <= cmd;
		index   <= idx;
		value   <= val;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		// taken at this edge; the local list moves on even for typed-in rows
		predict_list_op(cmd, idx, val, res);
		outcomes_due.push_back(fixed ? fixed_res : res);
		if ($urandom_range(99) < idle_pct) begin
			start   <= 1'b0;
			command <= 3'($urandom);
			index   <= IDX_W'($urandom);
			value   <= $urandom;
			repeat ($urandom_range(1, 4))
				@(posedge clk);
		end
	endtask

	// results: every strobe must match the oldest outstanding item
	always @(posedge clk) begin : result_check
		list_outcome_t want;
		if (done) begin
			if (outcomes_due.size() == 0) begin
				report_mismatch("result with no item outstanding", 32'(status), 0);
			end else begin
				want = outcomes_due.pop_front();
				if (status !== want.st)
					report_mismatch("status", 32'(status), 32'(want.st));
				if (read_value !== want.rd)
					report_mismatch("read_value", read_value, want.rd);
				if (count !== want.cnt)
					report_mismatch("count", 32'(count), 32'(want.cnt));
			end
		end
	end

	initial begin : stimulus
		int            n;
		int            phase;
		int            r;
		int            wait_cycles;
		int            idle_pct;
		logic          filling;
		logic [2:0]    cmd;
		logic [IDX_W-1:0] idx;
		logic [VAL_W-1:0] val;
		list_outcome_t typed;
		int            phase_idle [4];

		// no idling, mostly idle, lightly idle, then back to full rate
		phase_idle = '{0, 83, 20, 0};
		filling = 1'b1;

		repeat (12)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		for (n = 0; n < N_DIRECTED; n++) begin
			typed.st  = directed_rows[n].st;
			typed.rd  = directed_rows[n].rd;
			typed.cnt = directed_rows[n].cnt;
			issue_item(directed_rows[n].cmd, directed_rows[n].idx, directed_rows[n].val,
				directed_rows[n].fixed, typed, 0);
		end

		// random traffic: the list drifts between empty and full so that every
		// depth is visited and the full-list errors come up now and then
		for (phase = 0; phase < 4; phase++) begin
			idle_pct = phase_idle[phase];
			for (n = 0; n < PHASE_ITEMS; n++) begin
				// linger at the extremes for a few items before turning round
				if (list_fill >= DEPTH && $urandom_range(3) == 0)
					filling = 1'b0;
				else if (list_fill == 0 && $urandom_range(1) == 0)
					filling = 1'b1;
				else if ($urandom_range(99) == 0)
					filling = ~filling;

				r = $urandom_range(99);
				if (r < 4)
					cmd = 3'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
				else if (filling)
					cmd = (r < 40) ? CMD_APPEND : (r < 70) ? CMD_INSERT :
						(r < 85) ? CMD_READ : (r < 93) ? CMD_REMOVE : CMD_DROP;
				else
					cmd = (r < 35) ? CMD_REMOVE : (r < 65) ? CMD_DROP :
						(r < 80) ? CMD_READ : (r < 88) ? CMD_INSERT : CMD_APPEND;

				// mostly a live entry, sometimes the end position, else anything
				r = $urandom_range(99);
				if (list_fill > 0 && r < 85)
					idx = IDX_W'($urandom_range(list_fill - 1));
				else if (list_fill < DEPTH && r < 90)
					idx = IDX_W'(list_fill);
				else
					idx = IDX_W'($urandom);

				case ($urandom_range(19))
					0:       val = 32'h8000_0000;
					1:       val = 32'h7fff_ffff;
					2:       val = 32'hffff_ffff;
					3:       val = 32'h0000_0000;
					default: val = $urandom;
				endcase

				issue_item(cmd, idx, val, 1'b0, typed, idle_pct);
			end
		end

		start <= 1'b0;

		// drain: each result comes on the cycle after its item, so this is quick
		wait_cycles = 0;
		while (outcomes_due.size() != 0 && wait_cycles < 1000) begin
			@(posedge clk);
			wait_cycles++;
		end
		if (outcomes_due.size() != 0)
			report_mismatch("items left without a result", 32'(outcomes_due.size()), 0);
		// keep clocking a little longer to catch any stray strobe
		repeat (4)
			@(posedge clk);

		if (mismatch_count == 0)
			$display("indexed_shift_array_test passed");
		else
			$display("indexed_shift_array_test failed");
		$finish;
	end

	// guard against a hang; the slowest run needs well under a tenth of this
	initial begin : watchdog
		#2_000_000;
		$display("indexed_shift_array_test failed");
		$finish;
	end

endmodule
